// ===== hw/rtl/ivl_pkg.sv =====
// Shared definitions for the info-string value lookup block.
// Holds constants, the command codes, the result record and the case fold.
// Used by ivl_key_store, ivl_parser and infostring_value_lookup.
package ivl_pkg;

  // Default capacity of the search key store, in bytes.
  localparam int unsigned KEY_MAX = 64;

  // Field separator and string terminator.
  localparam logic [7:0] SEP_CHAR = 8'h5C;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  // Lower-case letter range and the distance to upper case.
  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_SPAN  = 8'h1A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Command codes carried with each input beat.
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_INFO = 1'b1;

  // One result beat.
  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_valid;
    logic       found;
    logic       done_res;
  } result_t;

  // Folds a-z to A-Z; every other byte passes unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] rel;
    rel = b - LOWER_FIRST;
    if (rel < LOWER_SPAN) begin
      return b - CASE_OFFSET;
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/infostring_value_lookup.sv =====
// Info-string value lookup: search key loading and streaming key/value search.
// An accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless the result side stalls; the key byte for the next
// compare is prefetched from the key memory by a registered read, so no beat waits on it.
// Reset (rst_ni, asynchronous, active low) clears lookup and key control
// state; key memory is not cleared, and bytes past the key length decide no compare.
module infostring_value_lookup #(
  parameter int unsigned KeyMax = ivl_pkg::KEY_MAX
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] value_byte_o,
  output logic       value_valid_o,
  output logic       found_o,
  output logic       done_res_o
);

  localparam int unsigned LenW = $clog2(KeyMax + 1);

  logic             in_valid_q;
  logic             cmd_q;
  logic [7:0]       byte_q;
  logic             out_valid_q;
  ivl_pkg::result_t res_q;
  ivl_pkg::result_t res;
  logic             out_ready;
  logic             go;
  logic [LenW-1:0]  key_len;
  logic             key_ovf;
  logic [7:0]       key_byte;
  logic [LenW-1:0]  next_pos;

  // Handshake: the input register drains whenever the result register
  // is empty or its beat is being taken.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign go         = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q  <= command_i;
      byte_q <= data_byte_i;
    end
  end

  ivl_key_store #(
    .KeyMax (KeyMax),
    .LenW   (LenW)
  ) u_key_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .command_i   (cmd_q),
    .data_byte_i (byte_q),
    .rd_pos_i    (next_pos),
    .key_len_o   (key_len),
    .key_ovf_o   (key_ovf),
    .key_byte_o  (key_byte)
  );

  ivl_parser #(
    .KeyMax (KeyMax),
    .LenW   (LenW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .command_i   (cmd_q),
    .data_byte_i (byte_q),
    .key_len_i   (key_len),
    .key_ovf_i   (key_ovf),
    .key_byte_i  (key_byte),
    .next_pos_o  (next_pos),
    .result_o    (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_byte_o  = res_q.value_byte;
  assign value_valid_o = res_q.value_valid;
  assign found_o       = res_q.found;
  assign done_res_o    = res_q.done_res;

  // A key beat always yields an all-zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   go && cmd_q == ivl_pkg::CMD_KEY |=> res_q == '0)
    else $error("key beat produced a nonzero result");
  // Value bytes are only emitted for a matched key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && value_valid_o |-> found_o && !done_res_o)
    else $error("value byte without a match");
  // An emitted value byte is never a separator or terminator.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && value_valid_o |->
                   value_byte_o != ivl_pkg::SEP_CHAR && value_byte_o != ivl_pkg::NUL_CHAR)
    else $error("separator or terminator emitted as value");

endmodule

// ===== hw/rtl/ivl_key_store.sv =====
// Search key store: key byte memory, key length and overflow tracking.
// Provides a registered read of the key byte that the parser needs next.
// Depends on ivl_pkg.
module ivl_key_store #(
  parameter int unsigned KeyMax = ivl_pkg::KEY_MAX,
  parameter int unsigned LenW   = $clog2(KeyMax + 1),
  parameter int unsigned AddrW  = (KeyMax > 1) ? $clog2(KeyMax) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic             command_i,
  input  logic [7:0]       data_byte_i,
  input  logic [LenW-1:0]  rd_pos_i,
  output logic [LenW-1:0]  key_len_o,
  output logic             key_ovf_o,
  output logic [7:0]       key_byte_o
);

  logic [7:0]      mem_q [KeyMax];
  logic [7:0]      rd_q;
  logic [LenW-1:0] key_len_q, key_len_d;
  logic            key_ovf_q, key_ovf_d;
  logic            key_cmpl_q, key_cmpl_d;
  logic            wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [LenW-1:0] len_base;

  // Key byte handling: a byte after a terminated key starts a new key.
  always_comb begin
    len_base   = key_cmpl_q ? '0 : key_len_q;
    key_len_d  = key_len_q;
    key_ovf_d  = key_ovf_q;
    key_cmpl_d = key_cmpl_q;
    wr_en      = 1'b0;
    if (go_i && command_i == ivl_pkg::CMD_KEY) begin
      key_len_d  = len_base;
      key_ovf_d  = key_cmpl_q ? 1'b0 : key_ovf_q;
      key_cmpl_d = 1'b0;
      if (data_byte_i == ivl_pkg::NUL_CHAR) begin
        key_cmpl_d = 1'b1;
      end else if (len_base < LenW'(KeyMax)) begin
        wr_en     = 1'b1;
        key_len_d = len_base + LenW'(1);
      end else begin
        key_ovf_d = 1'b1;
      end
    end
  end

  assign wr_addr = len_base[AddrW-1:0];
  assign rd_addr = rd_pos_i[AddrW-1:0];

  // Key memory with a registered read; a same-cycle write to the read
  // address is forwarded so the next beat sees the new byte.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= data_byte_i;
    end
    if (wr_en && wr_addr == rd_addr) begin
      rd_q <= data_byte_i;
    end else begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Key control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q  <= '0;
      key_ovf_q  <= 1'b0;
      key_cmpl_q <= 1'b1;
    end else begin
      key_len_q  <= key_len_d;
      key_ovf_q  <= key_ovf_d;
      key_cmpl_q <= key_cmpl_d;
    end
  end

  assign key_len_o  = key_len_q;
  assign key_ovf_o  = key_ovf_q;
  assign key_byte_o = rd_q;

endmodule

// ===== hw/rtl/ivl_parser.sv =====
// Info string parser: tracks the field phase, compares field keys with the
// search key and forms the result of each beat. Depends on ivl_pkg.
module ivl_parser #(
  parameter int unsigned KeyMax = ivl_pkg::KEY_MAX,
  parameter int unsigned LenW   = $clog2(KeyMax + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic               command_i,
  input  logic [7:0]         data_byte_i,
  input  logic [LenW-1:0]    key_len_i,
  input  logic               key_ovf_i,
  input  logic [7:0]         key_byte_i,
  output logic [LenW-1:0]    next_pos_o,
  output ivl_pkg::result_t   result_o
);

  typedef enum logic [1:0] {
    PhStart,
    PhKey,
    PhValue,
    PhSkip
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic            mism_q, mism_d;
  logic            match_q, match_d;
  logic            lead_sep;
  logic            finish;

  // Per-beat parse step.
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    mism_d   = mism_q;
    match_d  = match_q;
    lead_sep = 1'b0;
    finish   = 1'b0;
    result_o = '0;
    if (go_i) begin
      if (command_i == ivl_pkg::CMD_KEY) begin
        // A key byte abandons any lookup in progress.
        phase_d = PhStart;
        pos_d   = '0;
        mism_d  = 1'b0;
        match_d = 1'b0;
      end else begin
        if (phase_q == PhStart) begin
          phase_d  = PhKey;
          pos_d    = '0;
          mism_d   = 1'b0;
          lead_sep = (data_byte_i == ivl_pkg::SEP_CHAR);
        end
        if (!lead_sep) begin
          case (phase_d)
            PhKey: begin
              if (data_byte_i == ivl_pkg::NUL_CHAR) begin
                finish = 1'b1;
              end else if (data_byte_i == ivl_pkg::SEP_CHAR) begin
                match_d = !mism_d && !key_ovf_i && (pos_d == key_len_i);
                phase_d = PhValue;
              end else begin
                if (pos_d >= key_len_i || pos_d >= LenW'(KeyMax) ||
                    ivl_pkg::fold_case(data_byte_i) != ivl_pkg::fold_case(key_byte_i)) begin
                  mism_d = 1'b1;
                end
                if (pos_d < LenW'(KeyMax)) begin
                  pos_d = pos_d + LenW'(1);
                end
              end
            end
            PhValue: begin
              if (data_byte_i == ivl_pkg::NUL_CHAR) begin
                finish = 1'b1;
              end else if (data_byte_i == ivl_pkg::SEP_CHAR) begin
                if (match_d) begin
                  phase_d = PhSkip;
                end else begin
                  phase_d = PhKey;
                  pos_d   = '0;
                  mism_d  = 1'b0;
                end
              end else if (match_d) begin
                result_o.value_byte  = data_byte_i;
                result_o.value_valid = 1'b1;
              end
            end
            PhSkip: begin
              if (data_byte_i == ivl_pkg::NUL_CHAR) begin
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b0;
            end
          endcase
          result_o.found    = match_d;
          result_o.done_res = finish;
          if (finish) begin
            phase_d = PhStart;
            pos_d   = '0;
            mism_d  = 1'b0;
            match_d = 1'b0;
          end
        end
      end
    end
  end

  // The key store prefetches the byte at the next compare position.
  assign next_pos_o = pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      pos_q   <= '0;
      mism_q  <= 1'b0;
      match_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      mism_q  <= mism_d;
      match_q <= match_d;
    end
  end

  // The compare position never passes the key store capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= LenW'(KeyMax))
    else $error("compare position beyond key capacity");
  // Each lookup starts from a clean field state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   phase_q == PhStart |-> (pos_q == '0 && !mism_q && !match_q))
    else $error("lookup start with stale field state");
  // Skipping remaining fields only happens after a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q == PhSkip |-> match_q)
    else $error("skip phase without a match");

endmodule

// ===== tb/infostring_value_lookup_tb.sv =====
// Self-checking testbench for the info-string value lookup block.
// Predicts every result beat from the accepted input beats and checks it.
// Depends on ivl_pkg and on infostring_value_lookup from the RTL.
module infostring_value_lookup_tb;

  localparam int unsigned ITEM_TARGET  = 1400;
  localparam int unsigned PHASE_ITEMS  = 467;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PRINT_LIMIT  = 30;

  typedef enum logic [1:0] {
    SCAN_START,
    SCAN_KEY,
    SCAN_VALUE,
    SCAN_SKIP
  } scan_phase_e;

  // Scoreboard: tracks the lookup state and queues the result of each beat.
  class value_lookup_sb;
    logic [7:0]       key_bytes [ivl_pkg::KEY_MAX];
    int unsigned      key_len;
    bit               key_over;
    bit               key_closed;
    scan_phase_e      phase;
    int unsigned      field_pos;
    bit               field_bad;
    bit               matched;
    ivl_pkg::result_t expected_q [$];
    int unsigned      error_count;
    int unsigned      result_index;

    function new();
      key_len      = 0;
      key_over     = 1'b0;
      key_closed   = 1'b1;
      error_count  = 0;
      result_index = 0;
      restart_scan();
    endfunction

    function void restart_scan();
      phase     = SCAN_START;
      field_pos = 0;
      field_bad = 1'b0;
      matched   = 1'b0;
    endfunction

    // Only letters a-z are raised; everything else compares as is.
    function logic [7:0] upper_byte(logic [7:0] b);
      if (b >= ivl_pkg::LOWER_FIRST && b < ivl_pkg::LOWER_FIRST + ivl_pkg::LOWER_SPAN) begin
        return b - ivl_pkg::CASE_OFFSET;
      end
      return b;
    endfunction

    // Advances the lookup state by one input beat and returns its result.
    function ivl_pkg::result_t predict_lookup(logic cmd, logic [7:0] b);
      ivl_pkg::result_t r;
      bit               finish;
      r      = '0;
      finish = 1'b0;

      // Key bytes build the search key and abandon any lookup in progress.
      if (cmd == ivl_pkg::CMD_KEY) begin
        if (key_closed) begin
          key_len    = 0;
          key_over   = 1'b0;
          key_closed = 1'b0;
        end
        if (b == ivl_pkg::NUL_CHAR) begin
          key_closed = 1'b1;
        end else if (key_len < ivl_pkg::KEY_MAX) begin
          key_bytes[key_len] = b;
          key_len++;
        end else begin
          key_over = 1'b1;
        end
        restart_scan();
        return r;
      end

      // A single leading separator is swallowed.
      if (phase == SCAN_START) begin
        phase     = SCAN_KEY;
        field_pos = 0;
        field_bad = 1'b0;
        if (b == ivl_pkg::SEP_CHAR) begin
          return r;
        end
      end

      case (phase)
        SCAN_KEY: begin
          if (b == ivl_pkg::NUL_CHAR) begin
            finish = 1'b1;
          end else if (b == ivl_pkg::SEP_CHAR) begin
            matched = !field_bad && !key_over && field_pos == key_len;
            phase   = SCAN_VALUE;
          end else begin
            if (field_pos >= key_len || field_pos >= ivl_pkg::KEY_MAX ||
                upper_byte(b) != upper_byte(key_bytes[field_pos])) begin
              field_bad = 1'b1;
            end
            if (field_pos < ivl_pkg::KEY_MAX) begin
              field_pos++;
            end
          end
        end
        SCAN_VALUE: begin
          if (b == ivl_pkg::NUL_CHAR) begin
            finish = 1'b1;
          end else if (b == ivl_pkg::SEP_CHAR) begin
            if (matched) begin
              phase = SCAN_SKIP;
            end else begin
              phase     = SCAN_KEY;
              field_pos = 0;
              field_bad = 1'b0;
            end
          end else if (matched) begin
            r.value_byte  = b;
            r.value_valid = 1'b1;
          end
        end
        default: begin
          if (b == ivl_pkg::NUL_CHAR) begin
            finish = 1'b1;
          end
        end
      endcase

      r.found = matched;
      if (finish) begin
        r.done_res = 1'b1;
        restart_scan();
      end
      return r;
    endfunction

    function void note_beat(logic cmd, logic [7:0] b);
      expected_q.push_back(predict_lookup(cmd, b));
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      if (error_count < PRINT_LIMIT) begin
        $display("lookup check: result %0d %s got %0h want %0h",
                 result_index, what, got, want);
      end
      error_count++;
    endtask

    // Compares one accepted result beat with the oldest prediction.
    task check_beat(ivl_pkg::result_t got);
      ivl_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, value_byte", got.value_byte, 8'h00);
        result_index++;
        return;
      end
      want = expected_q.pop_front();
      if (got.value_byte !== want.value_byte) begin
        report_mismatch("value_byte", got.value_byte, want.value_byte);
      end
      if (got.value_valid !== want.value_valid) begin
        report_mismatch("value_valid", 8'(got.value_valid), 8'(want.value_valid));
      end
      if (got.found !== want.found) begin
        report_mismatch("found", 8'(got.found), 8'(want.found));
      end
      if (got.done_res !== want.done_res) begin
        report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
      end
      result_index++;
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       command_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] value_byte_o;
  logic       value_valid_o;
  logic       found_o;
  logic       done_res_o;

  value_lookup_sb lookup_sb;
  int unsigned    tx_idle_pct;
  int unsigned    rx_stall_pct;
  int unsigned    beats_sent;
  bit             hold_request;
  logic [7:0]     probe_key [$];
  bit             key_open;

  infostring_value_lookup dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_byte_o (value_byte_o),
    .value_valid_o(value_valid_o),
    .found_o      (found_o),
    .done_res_o   (done_res_o)
  );

  // Clock with a period of two time units.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Both channels are observed at the edge on which a beat is taken.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      lookup_sb.note_beat(command_i, data_byte_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      lookup_sb.check_beat({value_byte_o, value_valid_o, found_o, done_res_o});
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Ends the run when neither channel moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("infostring_value_lookup: mismatch");
    $finish;
  end

  // Offers one beat after an optional random gap and waits until it is taken.
  task automatic send_beat(input logic cmd, input logic [7:0] value);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (lookup_sb.outstanding() != 0);
  endtask

  // Mostly letters of either case, sometimes any nonzero byte.
  function automatic logic [7:0] rand_key_char();
    if ($urandom_range(4) != 0) begin
      return 8'($urandom_range(25)) + ($urandom_range(1) ? ivl_pkg::LOWER_FIRST : 8'h41);
    end
    return 8'($urandom_range(255, 1));
  endfunction

  function automatic logic [7:0] random_case(logic [7:0] b);
    logic [7:0] lower;
    lower = b | ivl_pkg::CASE_OFFSET;
    if (lower >= ivl_pkg::LOWER_FIRST &&
        lower < ivl_pkg::LOWER_FIRST + ivl_pkg::LOWER_SPAN) begin
      return $urandom_range(1) ? lower : lower & ~ivl_pkg::CASE_OFFSET;
    end
    return b;
  endfunction

  // Loads a search key, usually short, now and then past the store size.
  // An open key is extended rather than replaced.
  task automatic load_search_key();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(19);
    if (pick == 0) begin
      n = $urandom_range(70, 60);
    end else if (pick < 3) begin
      n = $urandom_range(20, 9);
    end else begin
      n = $urandom_range(8);
    end
    if (!key_open) begin
      probe_key.delete();
    end
    repeat (n) begin
      b = rand_key_char();
      probe_key.push_back(b);
      send_beat(ivl_pkg::CMD_KEY, b);
    end
    if ($urandom_range(9) == 0) begin
      key_open = 1'b1;
    end else begin
      send_beat(ivl_pkg::CMD_KEY, ivl_pkg::NUL_CHAR);
      key_open = 1'b0;
    end
  endtask

  // Sends one field key: the search key in random case, a near miss of it,
  // an overlong field or a short random one.
  task automatic send_field_key(input bit aim_hit);
    int unsigned mode;
    int unsigned n;
    logic [7:0]  b;
    mode = aim_hit ? 0 : $urandom_range(9, 1);
    if (mode == 0) begin
      n = probe_key.size();
    end else if (mode == 1) begin
      n = $urandom_range(72, 66);
    end else if (mode <= 4) begin
      n = probe_key.size() + $urandom_range(1);
      if (n != 0 && $urandom_range(1)) begin
        n--;
      end
    end else begin
      n = $urandom_range(6);
    end
    for (int i = 0; i < n; i++) begin
      if (mode != 1 && mode <= 4 && i < probe_key.size()) begin
        b = random_case(probe_key[i]);
        if (mode != 0 && i == n - 1 && n == probe_key.size()) begin
          b = rand_key_char();
        end
      end else begin
        b = rand_key_char();
      end
      send_beat(ivl_pkg::CMD_INFO, b);
    end
  endtask

  // Streams one info string of key/value pairs, usually holding the key once.
  task automatic send_info_string();
    int unsigned pairs;
    int unsigned hit;
    logic [7:0]  b;
    pairs = $urandom_range(4);
    hit   = $urandom_range(pairs);
    if ($urandom_range(1)) begin
      send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    end
    for (int i = 0; i < pairs; i++) begin
      send_field_key(i == hit);
      send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
      repeat ($urandom_range(5)) begin
        do b = 8'($urandom_range(255, 1)); while (b == ivl_pkg::SEP_CHAR);
        send_beat(ivl_pkg::CMD_INFO, b);
      end
      if (i != pairs - 1) begin
        send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
      end
    end
    // Sometimes the string ends inside a trailing key, sometimes not at all.
    if (pairs != 0 && $urandom_range(9) == 0) begin
      send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
      send_field_key(1'b0);
    end
    if ($urandom_range(9) != 0) begin
      send_beat(ivl_pkg::CMD_INFO, ivl_pkg::NUL_CHAR);
    end
  endtask

  // Unstructured beats with random command and byte.
  task automatic send_noise();
    repeat ($urandom_range(6, 1)) begin
      send_beat(logic'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned idle_phase;
    lookup_sb    = new();
    tx_idle_pct  = 23;
    rx_stall_pct = 81;
    beats_sent   = 0;
    hold_request = 1'b0;
    key_open     = 1'b0;
    idle_phase   = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    command_i   <= ivl_pkg::CMD_KEY;
    data_byte_i <= ivl_pkg::NUL_CHAR;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Lower-case key matched by an upper-case field; value, skip, found on NUL.
    send_beat(ivl_pkg::CMD_KEY, 8'h61);
    send_beat(ivl_pkg::CMD_KEY, ivl_pkg::NUL_CHAR);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    send_beat(ivl_pkg::CMD_INFO, 8'h41);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    send_beat(ivl_pkg::CMD_INFO, 8'hFF);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    send_beat(ivl_pkg::CMD_INFO, 8'h01);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::NUL_CHAR);
    // Empty field key against a nonempty key, then NUL inside a field key.
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    send_beat(ivl_pkg::CMD_INFO, 8'h80);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    send_beat(ivl_pkg::CMD_INFO, 8'h62);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::NUL_CHAR);
    // A key byte aborts the lookup and starts an open key used right away.
    send_beat(ivl_pkg::CMD_INFO, 8'h41);
    send_beat(ivl_pkg::CMD_KEY, 8'h7F);
    send_beat(ivl_pkg::CMD_INFO, 8'h7F);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    send_beat(ivl_pkg::CMD_INFO, 8'h55);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::NUL_CHAR);
    // Close the open key, then load an empty key and match an empty field.
    send_beat(ivl_pkg::CMD_KEY, ivl_pkg::NUL_CHAR);
    send_beat(ivl_pkg::CMD_KEY, ivl_pkg::NUL_CHAR);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::SEP_CHAR);
    send_beat(ivl_pkg::CMD_INFO, 8'hAA);
    send_beat(ivl_pkg::CMD_INFO, ivl_pkg::NUL_CHAR);

    // Random part in three idling phases; mostly well-formed lookups.
    while (beats_sent < ITEM_TARGET) begin
      if (idle_phase == 0 && beats_sent >= PHASE_ITEMS) begin
        wait_for_results();
        tx_idle_pct  = 81;
        rx_stall_pct = 23;
        idle_phase   = 1;
      end else if (idle_phase == 1 && beats_sent >= 2 * PHASE_ITEMS) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        idle_phase   = 2;
      end
      pick = $urandom_range(19);
      if (pick == 0) begin
        send_noise();
      end else begin
        if (pick < 9) begin
          load_search_key();
        end
        send_info_string();
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (lookup_sb.error_count == 0 && lookup_sb.outstanding() == 0) begin
      $display("infostring_value_lookup: match");
    end else begin
      $display("infostring_value_lookup: mismatch");
    end
    $finish;
  end

endmodule
